FILE: design/flash_gc_victim_select_assert.svh
// assertion macros shared by the victim select rtl
// needs clk and rst_n in the scope of each use
`ifndef FLASH_GC_VICTIM_SELECT_ASSERT_SVH
`define FLASH_GC_VICTIM_SELECT_ASSERT_SVH
`ifndef SYNTHESIS
`define FGVS_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define FGVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FGVS_ASSERT_HOLDS(lbl, expr, msg)
`define FGVS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/fgvs_pkg.sv
// shared types and constants for the gc victim selector
// no dependencies
package fgvs_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = 10;
  localparam int PAGE_W     = 7;
  localparam int ERASE_W    = 11;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 2);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int ENTRY_W    = PAGE_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BLOCK  = 3'd0,
    REG_END_BLOCK    = 3'd1,
    REG_PAGES_MAX    = 3'd2,
    REG_PASSIVE_LIM  = 3'd3,
    REG_PASSIVE_CAP  = 3'd4,
    REG_RESERVED     = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [BLK_W-1:0]  start_block;
    logic [BLK_W-1:0]  end_block;
    logic [PAGE_W-1:0] pages_max_block;
    logic [PAGE_W-1:0] passive_limit;
    logic [BLK_W-1:0]  passive_scan_cap;
    logic [BLK_W-1:0]  reserved_blocks;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic clear_en;
    logic upd_en;
    logic setup;
    logic scan_en;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic scan_end;
  } dp_sts_t;

endpackage

FILE: design/flash_gc_victim_select.sv
// top level of the flash gc victim selector
// depends on fgvs_pkg, fgvs_cfg_regs, fgvs_ctrl and fgvs_datapath
//
//  channel  handshake          beat
//  in_      start / busy       kind, block index, full flag, page counts, erased count
//  out_     out_valid strobe   victim valid, victim block, aggressive, gc fail
//  cfg_     cfg_valid/ready    register index, write data
//
// an update passes through the update state before it strobes its result; busy drops in the strobe cycle
// a victim request passes setup, a scan of the range and the done state before it strobes;
//   the scan is skipped for an empty range or zero threshold and stops early on an empty full block;
//   the scan reads through the single read port of the block table, one entry per cycle
// after reset the table is cleared one entry per cycle, with busy high until the clear pass ends
// the result strobe lasts one cycle and cannot be held off by the receiver
module flash_gc_victim_select (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [fgvs_pkg::BLK_W-1:0]    in_block_index,
  input  logic                          in_block_full,
  input  logic [fgvs_pkg::PAGE_W-1:0]   in_pages_in_use,
  input  logic [fgvs_pkg::PAGE_W-1:0]   in_soft_deleted,
  input  logic [fgvs_pkg::ERASE_W-1:0]  in_erased_count,
  // result channel
  output logic                          out_valid,
  output logic                          out_victim_valid,
  output logic [fgvs_pkg::BLK_W-1:0]    out_victim_block,
  output logic                          out_aggressive,
  output logic                          out_gc_fail,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fgvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgvs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fgvs_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file; the user must write it only while idle, the block itself does not enforce this
  fgvs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: clear pass, update, scan setup, scan, result
  fgvs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  // block table, cursor and compare datapath
  fgvs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_block_index   (in_block_index),
    .in_block_full    (in_block_full),
    .in_pages_in_use  (in_pages_in_use),
    .in_soft_deleted  (in_soft_deleted),
    .in_erased_count  (in_erased_count),
    .out_valid        (out_valid),
    .out_victim_valid (out_victim_valid),
    .out_victim_block (out_victim_block),
    .out_aggressive   (out_aggressive),
    .out_gc_fail      (out_gc_fail)
  );

endmodule

FILE: design/fgvs_cfg_regs.sv
// configuration register file of the gc victim selector
// depends on fgvs_pkg
module fgvs_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fgvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgvs_pkg::CFG_DATA_W-1:0] cfg_data,
  output fgvs_pkg::cfg_t               cfg
);
  import fgvs_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_block      <= BLK_W'(0);
      cfg_r.end_block        <= BLK_W'(1023);
      cfg_r.pages_max_block  <= PAGE_W'(64);
      cfg_r.passive_limit    <= PAGE_W'(3);
      cfg_r.passive_scan_cap <= BLK_W'(200);
      cfg_r.reserved_blocks  <= BLK_W'(2);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_BLOCK: cfg_r.start_block      <= cfg_data[BLK_W-1:0];
        REG_END_BLOCK:   cfg_r.end_block        <= cfg_data[BLK_W-1:0];
        REG_PAGES_MAX:   cfg_r.pages_max_block  <= cfg_data[PAGE_W-1:0];
        REG_PASSIVE_LIM: cfg_r.passive_limit    <= cfg_data[PAGE_W-1:0];
        REG_PASSIVE_CAP: cfg_r.passive_scan_cap <= cfg_data[BLK_W-1:0];
        REG_RESERVED:    cfg_r.reserved_blocks  <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/fgvs_ctrl.sv
// sequencing state machine of the gc victim selector
// depends on fgvs_pkg and the assertion header
`include "flash_gc_victim_select_assert.svh"
module fgvs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_kind,
  output logic               busy,
  output fgvs_pkg::dp_cmd_t  cmd,
  input  fgvs_pkg::dp_sts_t  sts
);
  import fgvs_pkg::*;

  ctrl_state_t state_r, state_nxt;
  // commands that own a state; finish rides along with an update
  logic [4:0]  cmd_act;
  logic        setup_skip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = in_kind ? ST_SETUP : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.upd_en = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.skip ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  assign cmd_act    = {cmd.accept, cmd.clear_en, cmd.upd_en, cmd.setup, cmd.scan_en};
  assign setup_skip = (state_r == ST_SETUP) && sts.skip;

  `FGVS_ASSERT_HOLDS(a_one_cmd, $onehot0(cmd_act), "more than one datapath command")
  `FGVS_ASSERT_NEXT(a_skip_done, setup_skip, state_r == ST_DONE, "skip did not go to done")
  `FGVS_ASSERT_NEXT(a_finish_idle, cmd.finish, !busy, "not idle after finish")

endmodule

FILE: design/fgvs_datapath.sv
// block table, scan cursor and scan datapath of the gc victim selector
// depends on fgvs_pkg and the assertion header
`include "flash_gc_victim_select_assert.svh"
module fgvs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fgvs_pkg::cfg_t                cfg,
  input  fgvs_pkg::dp_cmd_t             cmd,
  output fgvs_pkg::dp_sts_t             sts,
  input  logic                          in_kind,
  input  logic [fgvs_pkg::BLK_W-1:0]    in_block_index,
  input  logic                          in_block_full,
  input  logic [fgvs_pkg::PAGE_W-1:0]   in_pages_in_use,
  input  logic [fgvs_pkg::PAGE_W-1:0]   in_soft_deleted,
  input  logic [fgvs_pkg::ERASE_W-1:0]  in_erased_count,
  output logic                          out_valid,
  output logic                          out_victim_valid,
  output logic [fgvs_pkg::BLK_W-1:0]    out_victim_block,
  output logic                          out_aggressive,
  output logic                          out_gc_fail
);
  import fgvs_pkg::*;

  // block table: full flag over live page count
  logic [ENTRY_W-1:0] mem [NUM_BLOCKS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [BLK_W-1:0]   rd_addr;
  logic               wr_en;
  logic [BLK_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // latched item
  logic               kind_r;
  logic [BLK_W-1:0]   idx_r;
  logic               full_r;
  logic [PAGE_W-1:0]  used_r;
  logic [ERASE_W-1:0] erased_r;

  // scan state
  logic [BLK_W-1:0]   clr_r;
  logic [BLK_W-1:0]   cur_r, cur_nxt;
  logic [BLK_W-1:0]   addr_r, addr_nxt;
  logic [BLK_W-1:0]   lo_r, hi_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PAGE_W-1:0]  thr_r, thr_nxt;
  logic               pend_r, pend_nxt;
  logic [BLK_W-1:0]   pend_blk_r;
  logic               found_r, found_nxt;
  logic [BLK_W-1:0]   victim_r, victim_nxt;
  logic               aggr_r;

  logic               out_valid_r, out_vv_r, out_aggr_r, out_fail_r;
  logic [BLK_W-1:0]   out_blk_r;

  // setup terms
  logic [ERASE_W-1:0] res_plus1;
  logic               aggr_w;
  logic [BLK_W-1:0]   hi_w;
  logic [PAGE_W-1:0]  thr_w;
  logic [CNT_W-1:0]   range_w, iters_w, pass_w;
  logic               skip_w;

  // scan step terms
  logic [PAGE_W-1:0]  rd_live;
  logic               rd_full, hit, stop, issue;
  logic [BLK_W:0]     step_inc;
  logic [BLK_W-1:0]   step_w;
  logic [PAGE_W-1:0]  live_w;

  assign live_w = (in_pages_in_use > in_soft_deleted) ? (in_pages_in_use - in_soft_deleted)
                                                       : PAGE_W'(0);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_kind;
      idx_r    <= in_block_index;
      full_r   <= in_block_full;
      used_r   <= live_w;
      erased_r <= in_erased_count;
    end
  end

  // table write port: clearing pass or entry update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {full_r, used_r};
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (cmd.upd_en && ({1'b0, idx_r} < (BLK_W+1)'(NUM_BLOCKS))) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_r <= clr_r + BLK_W'(1);
    end
  end

  // setup: mode, threshold, clamped range and visit count
  assign res_plus1 = ERASE_W'(cfg.reserved_blocks) + ERASE_W'(1);
  assign aggr_w    = (erased_r <= res_plus1);
  assign hi_w      = ({1'b0, cfg.end_block} > (BLK_W+1)'(NUM_BLOCKS - 1))
                     ? BLK_W'(NUM_BLOCKS - 1) : cfg.end_block;
  assign thr_w     = aggr_w ? cfg.pages_max_block : cfg.passive_limit;
  assign range_w   = CNT_W'(hi_w) - CNT_W'(cfg.start_block) + CNT_W'(1);
  assign pass_w    = (range_w >> 4) > CNT_W'(cfg.passive_scan_cap)
                     ? CNT_W'(cfg.passive_scan_cap) : (range_w >> 4);
  assign iters_w   = aggr_w ? range_w : pass_w;
  assign skip_w    = (cfg.start_block > hi_w)
                     || ({1'b0, cfg.start_block} >= (BLK_W+1)'(NUM_BLOCKS))
                     || (thr_w == '0);

  // scan: compare the entry read last cycle, issue the next read
  assign rd_full  = rd_data_r[ENTRY_W-1];
  assign rd_live  = rd_data_r[PAGE_W-1:0];
  assign hit      = pend_r && rd_full && (rd_live < thr_r);
  assign step_inc = {1'b0, addr_r} + (BLK_W+1)'(1);
  assign step_w   = ((step_inc < {1'b0, lo_r}) || (step_inc > {1'b0, hi_r}))
                    ? lo_r : step_inc[BLK_W-1:0];
  assign stop     = hit && (rd_live == '0);
  assign issue    = (count_r != '0) && !stop;
  assign rd_addr  = step_w;

  always_comb begin
    cur_nxt    = cur_r;
    addr_nxt   = addr_r;
    count_nxt  = count_r;
    thr_nxt    = thr_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    victim_nxt = victim_r;
    if (cmd.setup) begin
      addr_nxt   = cur_r;
      count_nxt  = iters_w + CNT_W'(1);
      thr_nxt    = thr_w;
      pend_nxt   = 1'b0;
      found_nxt  = 1'b0;
      victim_nxt = '0;
    end else if (cmd.scan_en) begin
      if (pend_r) cur_nxt = pend_blk_r;
      if (hit) begin
        found_nxt  = 1'b1;
        victim_nxt = pend_blk_r;
        thr_nxt    = rd_live;
      end
      pend_nxt = issue;
      if (issue) begin
        addr_nxt  = step_w;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cur_r  <= cur_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    count_r    <= count_nxt;
    thr_r      <= thr_nxt;
    found_r    <= found_nxt;
    victim_r   <= victim_nxt;
    pend_blk_r <= step_w;
    if (cmd.setup) begin
      lo_r   <= cfg.start_block;
      hi_r   <= hi_w;
      aggr_r <= aggr_w;
    end
  end

  assign sts.clear_last = (clr_r == BLK_W'(NUM_BLOCKS - 1));
  assign sts.skip       = skip_w;
  assign sts.scan_end   = stop || ((count_r == '0) && !pend_r);

  // result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_vv_r   <= kind_r && found_r;
      out_blk_r  <= (kind_r && found_r) ? victim_r : '0;
      out_aggr_r <= kind_r && aggr_r;
      out_fail_r <= kind_r && aggr_r && !found_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_victim_valid = out_vv_r;
  assign out_victim_block = out_blk_r;
  assign out_aggressive   = out_aggr_r;
  assign out_gc_fail      = out_fail_r;

  `FGVS_ASSERT_NEXT(a_hit_found, cmd.scan_en && hit, found_r, "hit not recorded")
  `FGVS_ASSERT_NEXT(a_stop_drains, cmd.scan_en && stop, !pend_r, "read left in flight after stop")
  `FGVS_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe longer than a cycle")

endmodule

FILE: verif/testbench.sv
// self-checking testbench for flash_gc_victim_select: directed and random beats
// depends on fgvs_pkg and the flash_gc_victim_select rtl, nothing else
module testbench;
  import fgvs_pkg::*;

  // item kinds and the register indexes that decode to nothing
  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int MAX_GAP = 11;
  localparam int PAGES_MAX = 64;

  typedef struct {
    logic              kind;
    logic [BLK_W-1:0]  index;
    logic              full;
    logic [PAGE_W-1:0] used;
    logic [PAGE_W-1:0] deleted;
    logic [ERASE_W-1:0] erased;
    int                gap;    // idle cycles before this beat is offered
    bit                drain;  // hold this beat until every result is back
  } gc_item_t;

  typedef struct {
    logic             victim_valid;
    logic [BLK_W-1:0] victim_block;
    logic             aggressive;
    logic             gc_fail;
  } gc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic [BLK_W-1:0] in_block_index = '0;
  logic in_block_full = 1'b0;
  logic [PAGE_W-1:0] in_pages_in_use = '0;
  logic [PAGE_W-1:0] in_soft_deleted = '0;
  logic [ERASE_W-1:0] in_erased_count = '0;
  logic out_valid;
  logic out_victim_valid;
  logic [BLK_W-1:0] out_victim_block;
  logic out_aggressive;
  logic out_gc_fail;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flash_gc_victim_select dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_block_index   (in_block_index),
    .in_block_full    (in_block_full),
    .in_pages_in_use  (in_pages_in_use),
    .in_soft_deleted  (in_soft_deleted),
    .in_erased_count  (in_erased_count),
    .out_valid        (out_valid),
    .out_victim_valid (out_victim_valid),
    .out_victim_block (out_victim_block),
    .out_aggressive   (out_aggressive),
    .out_gc_fail      (out_gc_fail),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the block table, the cursor and the registers
  logic              tbl_full [NUM_BLOCKS];
  logic [PAGE_W-1:0] tbl_live [NUM_BLOCKS];
  logic [BLK_W-1:0]  scan_pos = '0;
  logic [BLK_W-1:0]  cfg_start = 10'd0;
  logic [BLK_W-1:0]  cfg_end = 10'd1023;
  logic [PAGE_W-1:0] cfg_pmax = 7'd64;
  logic [PAGE_W-1:0] cfg_plimit = 7'd3;
  logic [BLK_W-1:0]  cfg_pcap = 10'd200;
  logic [BLK_W-1:0]  cfg_reserved = 10'd2;

  gc_item_t   pending_q [$];   // beats waiting for the driver
  gc_result_t victim_q [$];    // predicted results, oldest first
  gc_item_t   cur_item;
  int         gap_left = 0;
  bit         gap_armed = 1'b0;
  bit         burst = 1'b0;    // phase with no idle cycles on the sender
  int         n_errors = 0;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_START_BLOCK: cfg_start = val;
      REG_END_BLOCK:   cfg_end = val;
      REG_PAGES_MAX:   cfg_pmax = val[PAGE_W-1:0];
      REG_PASSIVE_LIM: cfg_plimit = val[PAGE_W-1:0];
      REG_PASSIVE_CAP: cfg_pcap = val;
      REG_RESERVED:    cfg_reserved = val;
      default: ;
    endcase
  endfunction

  // table write or victim scan, updating the shadow state as the block would
  function automatic gc_result_t predict_victim(input gc_item_t it);
    gc_result_t r;
    int lo, hi, thr, iters, b, i;
    r = '{victim_valid: 1'b0, victim_block: '0, aggressive: 1'b0, gc_fail: 1'b0};
    if (it.kind == KIND_UPDATE) begin
      if (int'(it.index) < NUM_BLOCKS) begin
        tbl_full[it.index] = it.full;
        // live count saturates at zero when soft deletes exceed pages in use
        tbl_live[it.index] = (it.used > it.deleted) ? it.used - it.deleted : '0;
      end
      return r;
    end
    r.aggressive = (int'(it.erased) <= int'(cfg_reserved) + 1);
    lo = int'(cfg_start);
    hi = (int'(cfg_end) > NUM_BLOCKS - 1) ? NUM_BLOCKS - 1 : int'(cfg_end);
    thr = r.aggressive ? int'(cfg_pmax) : int'(cfg_plimit);
    // empty range or zero threshold: cursor stays, nothing found
    if (lo <= hi && thr > 0) begin
      iters = r.aggressive ? hi - lo + 1 : (hi - lo + 1) / 16;
      if (!r.aggressive && iters > int'(cfg_pcap)) iters = int'(cfg_pcap);
      b = int'(scan_pos);
      for (i = 0; i <= iters && thr > 0; i++) begin
        b++;
        if (b < lo || b > hi) b = lo;
        if (tbl_full[b[BLK_W-1:0]] && int'(tbl_live[b[BLK_W-1:0]]) < thr) begin
          r.victim_valid = 1'b1;
          r.victim_block = b[BLK_W-1:0];
          thr = int'(tbl_live[b[BLK_W-1:0]]);
        end
      end
      scan_pos = b[BLK_W-1:0];
    end
    r.gc_fail = r.aggressive && !r.victim_valid;
    return r;
  endfunction

  // driver: offers one beat at a time, predicts on acceptance
  always @(posedge clk) begin
    logic next_start;
    next_start = start;
    if (!rst_n) begin
      next_start = 1'b0;
      gap_armed = 1'b0;
    end else begin
      if (start && !busy) begin
        victim_q.push_back(predict_victim(cur_item));
        next_start = 1'b0;
      end
      if (!next_start && pending_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left = pending_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_q[0].drain && victim_q.size() != 0)) begin
          cur_item = pending_q.pop_front();
          gap_armed = 1'b0;
          next_start = 1'b1;
          in_kind <= cur_item.kind;
          in_block_index <= cur_item.index;
          in_block_full <= cur_item.full;
          in_pages_in_use <= cur_item.used;
          in_soft_deleted <= cur_item.deleted;
          in_erased_count <= cur_item.erased;
        end
      end
    end
    // one assignment per edge keeps back-to-back beats glitch free
    start <= next_start;
  end

  // monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin
    gc_result_t want;
    if (rst_n && out_valid) begin
      if (victim_q.size() == 0) begin
        report_mismatch("result strobe with no beat outstanding");
      end else begin
        want = victim_q.pop_front();
        if (out_victim_valid !== want.victim_valid)
          report_mismatch($sformatf("victim_valid got %b want %b",
                                    out_victim_valid, want.victim_valid));
        if (out_victim_block !== want.victim_block)
          report_mismatch($sformatf("victim_block got %0d want %0d",
                                    out_victim_block, want.victim_block));
        if (out_aggressive !== want.aggressive)
          report_mismatch($sformatf("aggressive got %b want %b",
                                    out_aggressive, want.aggressive));
        if (out_gc_fail !== want.gc_fail)
          report_mismatch($sformatf("gc_fail got %b want %b",
                                    out_gc_fail, want.gc_fail));
      end
    end
  end

  task automatic add_update(input int idx, input bit full, input int used, input int deleted,
                            input bit hold);
    gc_item_t it;
    it.kind = KIND_UPDATE;
    it.index = idx[BLK_W-1:0];
    it.full = full;
    it.used = used[PAGE_W-1:0];
    it.deleted = deleted[PAGE_W-1:0];
    it.erased = ERASE_W'($urandom_range(0, 1024));   // ignored by an update
    it.gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    it.drain = hold;
    pending_q.push_back(it);
  endtask

  task automatic add_request(input int erased, input bit hold);
    gc_item_t it;
    // the table fields are noise for a request
    it.kind = KIND_REQUEST;
    it.index = BLK_W'($urandom_range(0, 1023));
    it.full = 1'($urandom_range(0, 1));
    it.used = PAGE_W'($urandom_range(0, PAGES_MAX));
    it.deleted = PAGE_W'($urandom_range(0, PAGES_MAX));
    it.erased = erased[ERASE_W-1:0];
    it.gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    it.drain = hold;
    pending_q.push_back(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int s, input int e, input int pm, input int pl,
                            input int cap, input int res);
    write_reg(REG_START_BLOCK, s[CFG_DATA_W-1:0]);
    write_reg(REG_END_BLOCK, e[CFG_DATA_W-1:0]);
    write_reg(REG_PAGES_MAX, pm[CFG_DATA_W-1:0]);
    write_reg(REG_PASSIVE_LIM, pl[CFG_DATA_W-1:0]);
    write_reg(REG_PASSIVE_CAP, cap[CFG_DATA_W-1:0]);
    write_reg(REG_RESERVED, res[CFG_DATA_W-1:0]);
  endtask

  // block idle: nothing queued, nothing in flight, every result back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_q.size() != 0 || start || victim_q.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int ph, n, s, e, pm, pl, cap, res, idx, used, deleted, er;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      tbl_full[k] = 1'b0;
      tbl_live[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // the table clear pass after reset keeps busy high
    wait_drained();

    // directed: reset settings, saturation, mode boundary, early stop, gc fail
    burst = 1'b1;
    add_update(5, 1'b1, 10, 3, 1'b0);
    add_update(1023, 1'b1, 0, 64, 1'b0);     // soft deletes exceed pages in use
    add_update(0, 1'b0, 64, 0, 1'b0);
    add_update(700, 1'b1, 64, 0, 1'b0);
    add_update(300, 1'b1, 2, 0, 1'b0);
    add_request(1024, 1'b1);                 // passive, pauses for a full drain
    burst = 1'b0;
    add_request(4, 1'b0);                    // just above reserve plus one: passive
    add_request(3, 1'b0);                    // reserve plus one: aggressive
    add_request(0, 1'b0);
    add_update(1023, 1'b0, 5, 5, 1'b0);
    add_request(0, 1'b0);
    add_update(5, 1'b0, 0, 0, 1'b0);
    add_update(300, 1'b0, 0, 0, 1'b0);
    add_update(700, 1'b0, 0, 0, 1'b0);
    add_request(2, 1'b0);                    // nothing full: aggressive failure
    wait_drained();

    // start above end: empty range
    set_config(600, 599, 64, 3, 200, 2);
    add_request(0, 1'b0);
    add_request(1024, 1'b0);
    wait_drained();

    // both thresholds zero
    set_config(0, 1023, 0, 0, 1023, 1023);
    add_request(0, 1'b0);
    add_request(1024, 1'b0);
    wait_drained();

    // one-block range at the top of the table, passive cap zero
    set_config(1023, 1023, 64, 64, 0, 0);
    write_reg(REG_SPARE_6, 10'h3ff);
    write_reg(REG_SPARE_7, 10'h3ff);
    add_update(1023, 1'b1, 1, 0, 1'b0);
    add_request(0, 1'b0);
    add_request(1024, 1'b0);
    add_update(1023, 1'b1, 0, 0, 1'b0);
    add_request(1024, 1'b0);
    wait_drained();

    // random phases: fresh settings each time, mostly small ranges
    for (ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 7))
        0: begin
          s = 0;
          e = 1023;
        end
        1: begin
          s = $urandom_range(1, 1023);
          e = $urandom_range(0, s - 1);
        end
        default: begin
          s = $urandom_range(0, 1023);
          e = s + $urandom_range(0, 63);
          if (e > 1023) e = 1023;
        end
      endcase
      pm = ($urandom_range(0, 9) == 0) ? 0 :
           ($urandom_range(0, 9) == 0) ? PAGES_MAX : $urandom_range(1, PAGES_MAX);
      pl = ($urandom_range(0, 9) == 0) ? 0 :
           ($urandom_range(0, 9) == 0) ? PAGES_MAX : $urandom_range(1, 8);
      cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 4);
      res = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 30);
      set_config(s, e, pm, pl, cap, res);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                  CFG_DATA_W'($urandom_range(0, 1023)));
      burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 46; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          // half the requests sit on the mode boundary
          if ($urandom_range(0, 1)) er = res + $urandom_range(0, 2);
          else er = $urandom_range(0, 1024);
          if (er > 1024) er = 1024;
          add_request(er, $urandom_range(0, 39) == 0);
        end else begin
          if (s <= e && $urandom_range(0, 4) != 0) idx = $urandom_range(s, e);
          else idx = $urandom_range(0, 1023);
          deleted = $urandom_range(0, PAGES_MAX);
          if ($urandom_range(0, 1)) used = $urandom_range(0, PAGES_MAX);
          else used = deleted + $urandom_range(0, 4);
          if (used > PAGES_MAX) used = PAGES_MAX;
          add_update(idx, $urandom_range(0, 9) < 7, used, deleted,
                     $urandom_range(0, 39) == 0);
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/fgvs_pkg.sv
design/fgvs_cfg_regs.sv
design/fgvs_ctrl.sv
design/fgvs_datapath.sv
design/flash_gc_victim_select.sv
verif/testbench.sv
